// ===== sv/rbwc_pkg.sv =====
// ----------------------------------------------------------------------------
// rbwc_pkg
// Shared types, codes and helpers for the radio band window controller.
// ----------------------------------------------------------------------------
`default_nettype none

package rbwc_pkg;

  localparam int unsigned CountW  = 16;
  localparam int unsigned TimeW   = 32;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CountW-1:0] CountMax = '1;

  // Reset values of the configuration registers.
  localparam logic        FixModeRst      = 1'b1;
  localparam logic [15:0] LatchTimeoutRst = 16'd1000;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_FIX_MODE      = 1'b0,
    CFG_LATCH_TIMEOUT = 1'b1
  } cfg_idx_e;

  // Event codes carried by one input beat.
  typedef enum logic [2:0] {
    EV_TICK          = 3'd0,
    EV_START_HF_TX   = 3'd1,
    EV_TX_COMPLETE   = 3'd2,
    EV_RECOVER_RX    = 3'd3,
    EV_PRI_TX_START  = 3'd4,
    EV_PRI_TX_DONE   = 3'd5,
    EV_HF_TX_LOST    = 3'd6,
    EV_QUEUE_HF_TX   = 3'd7
  } kind_e;

  typedef struct packed {
    logic        fix_mode;
    logic [15:0] latch_timeout_ms;
  } cfg_t;

  typedef struct packed {
    logic              band_hf;
    logic              radio_busy;
    logic              rx_armed;
    logic              hf_window;
    logic              tx_latch;
    logic [TimeW-1:0]  latch_stamp;
    logic              forced_modem;
    logic              pending_tx;
    logic [CountW-1:0] attempts;
    logic [CountW-1:0] bails;
    logic [CountW-1:0] force_clears;
  } state_t;

  localparam state_t StateRst = '{
    band_hf:      1'b0,
    radio_busy:   1'b0,
    rx_armed:     1'b1,
    hf_window:    1'b0,
    tx_latch:     1'b0,
    latch_stamp:  '0,
    forced_modem: 1'b0,
    pending_tx:   1'b0,
    attempts:     '0,
    bails:        '0,
    force_clears: '0
  };

  // Saturating increment of a status counter.
  function automatic logic [CountW-1:0] sat_inc(input logic [CountW-1:0] v);
    sat_inc = (v == CountMax) ? v : v + CountW'(1);
  endfunction

endpackage

`default_nettype wire

// ===== sv/rbwc_cfg.sv =====
// ----------------------------------------------------------------------------
// rbwc_cfg
// Configuration register file: fix mode and latch timeout.
// ----------------------------------------------------------------------------
`default_nettype none

module rbwc_cfg (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          wr_en_i,
  input  wire logic [rbwc_pkg::CfgIdxW-1:0]  wr_idx_i,
  input  wire logic [rbwc_pkg::CfgDataW-1:0] wr_data_i,
  output rbwc_pkg::cfg_t                     cfg_o
);

  rbwc_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      unique case (rbwc_pkg::cfg_idx_e'(wr_idx_i))
        rbwc_pkg::CFG_FIX_MODE:      cfg_d.fix_mode = wr_data_i[0];
        rbwc_pkg::CFG_LATCH_TIMEOUT: cfg_d.latch_timeout_ms = wr_data_i;
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fix_mode         <= rbwc_pkg::FixModeRst;
      cfg_q.latch_timeout_ms <= rbwc_pkg::LatchTimeoutRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== sv/rbwc_next.sv =====
// ----------------------------------------------------------------------------
// rbwc_next
// Next-state logic: applies one event to the controller state.
// ----------------------------------------------------------------------------
`default_nettype none

module rbwc_next (
  input  wire rbwc_pkg::cfg_t             cfg_i,
  input  wire rbwc_pkg::state_t           state_i,
  input  wire logic [2:0]                 kind_i,
  input  wire logic [rbwc_pkg::TimeW-1:0] time_now_i,
  output rbwc_pkg::state_t                state_o
);

  logic [rbwc_pkg::TimeW-1:0] latch_age;
  logic                       latch_expired;

  // Age is taken modulo 2^32, so a wrapped clock still gives the right answer.
  assign latch_age     = time_now_i - state_i.latch_stamp;
  assign latch_expired = latch_age >= {16'd0, cfg_i.latch_timeout_ms};

  always_comb begin
    rbwc_pkg::state_t s;
    logic             go;
    s  = state_i;
    go = 1'b1;
    unique case (rbwc_pkg::kind_e'(kind_i))
      rbwc_pkg::EV_TICK: begin
        if (s.tx_latch) begin
          if (!cfg_i.fix_mode || !latch_expired) begin
            go = 1'b0;
          end else begin
            s.tx_latch     = 1'b0;
            s.forced_modem = 1'b0;
            s.force_clears = rbwc_pkg::sat_inc(s.force_clears);
          end
        end
        if (go) begin
          if (!s.hf_window) begin
            // Opening only happens with the radio idle, so the switch succeeds.
            if (!s.radio_busy) begin
              s.attempts  = rbwc_pkg::sat_inc(s.attempts);
              s.band_hf   = 1'b1;
              s.rx_armed  = 1'b0;
              s.hf_window = 1'b1;
              if (s.pending_tx) begin
                s.pending_tx   = 1'b0;
                s.forced_modem = 1'b1;
                s.radio_busy   = 1'b1;
                s.tx_latch     = 1'b1;
                s.latch_stamp  = time_now_i;
              end
            end
          end else begin
            if (cfg_i.fix_mode) begin
              s.forced_modem = 1'b0;
            end
            s.attempts = rbwc_pkg::sat_inc(s.attempts);
            if (s.radio_busy) begin
              s.bails = rbwc_pkg::sat_inc(s.bails);
              // Legacy mode ignores the refusal and drops the window anyway.
              if (!cfg_i.fix_mode) begin
                s.hf_window = 1'b0;
              end
            end else begin
              s.band_hf   = 1'b0;
              s.rx_armed  = 1'b1;
              s.hf_window = 1'b0;
            end
          end
        end
      end
      rbwc_pkg::EV_START_HF_TX: begin
        if (!s.radio_busy) begin
          s.forced_modem = 1'b1;
          s.radio_busy   = 1'b1;
          s.tx_latch     = 1'b1;
          s.latch_stamp  = time_now_i;
        end
      end
      rbwc_pkg::EV_TX_COMPLETE: begin
        s.forced_modem = 1'b0;
        s.tx_latch     = 1'b0;
        s.radio_busy   = 1'b0;
      end
      rbwc_pkg::EV_RECOVER_RX: begin
        if (cfg_i.fix_mode) begin
          s.forced_modem = 1'b0;
          s.band_hf      = 1'b0;
          s.rx_armed     = 1'b1;
        end else if (s.forced_modem) begin
          s.band_hf  = 1'b1;
          s.rx_armed = 1'b0;
        end else begin
          s.band_hf  = 1'b0;
          s.rx_armed = 1'b1;
        end
      end
      rbwc_pkg::EV_PRI_TX_START: begin
        s.radio_busy = 1'b1;
        s.rx_armed   = 1'b0;
      end
      rbwc_pkg::EV_PRI_TX_DONE: begin
        s.radio_busy = 1'b0;
        s.rx_armed   = 1'b1;
      end
      rbwc_pkg::EV_HF_TX_LOST: begin
        s.radio_busy = 1'b0;
      end
      rbwc_pkg::EV_QUEUE_HF_TX: begin
        s.pending_tx = 1'b1;
      end
      default: s = state_i;
    endcase
    state_o = s;
  end

endmodule

`default_nettype wire

// ===== sv/radio_band_window_controller.sv =====
// ----------------------------------------------------------------------------
// radio_band_window_controller
// Time-division band window controller for a dual-band radio.
// ----------------------------------------------------------------------------
// Each input beat is one radio event (kind_i) with the current millisecond
// time (time_now_i). The block answers every event with exactly one result
// beat that reports the controller state after the event: band, window,
// receiver, busy, latch, forced-modem and queued flags, a consistency flag,
// and three saturating counters. An accepted event lands in an input
// register; the next-state logic then applies it to the state register,
// which doubles as the result register, once the result slot is free or
// being emptied. One event per cycle is sustained while results are taken.
// The input register keeps accepting while a result waits, until both are
// occupied; the critical path is the 32-bit latch age subtract and compare.
// Configuration writes (index 0 fix mode, index 1 latch timeout) are always
// ready and should only be issued while no event is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module radio_band_window_controller (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // Configuration write channel.
  input  wire logic                          cfg_valid_i,
  output      logic                          cfg_ready_o,
  input  wire logic [rbwc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [rbwc_pkg::CfgDataW-1:0] cfg_data_i,
  // Event channel.
  input  wire logic                          in_valid_i,
  output      logic                          in_ready_o,
  input  wire logic [2:0]                    kind_i,
  input  wire logic [31:0]                   time_now_i,
  // Result channel.
  output      logic                          out_valid_o,
  input  wire logic                          out_ready_i,
  output      logic                          band_is_hf_o,
  output      logic                          window_open_o,
  output      logic                          primary_rx_armed_o,
  output      logic                          tx_busy_o,
  output      logic                          latch_set_o,
  output      logic                          modem_forced_hf_o,
  output      logic                          tx_queued_o,
  output      logic                          state_consistent_o,
  output      logic [15:0]                   switch_attempt_count_o,
  output      logic [15:0]                   switch_bail_count_o,
  output      logic [15:0]                   latch_clear_count_o
);

  rbwc_pkg::cfg_t   cfg;
  rbwc_pkg::state_t state_q, state_d, state_nxt;

  logic        in_valid_q, in_valid_d;
  logic [2:0]  kind_q;
  logic [31:0] time_now_q;
  logic        out_valid_q, out_valid_d;
  logic        advance;
  logic        in_fire;

  // Configuration writes never stall.
  assign cfg_ready_o = 1'b1;

  rbwc_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cfg_valid_i),
    .wr_idx_i  (cfg_index_i),
    .wr_data_i (cfg_data_i),
    .cfg_o     (cfg)
  );

  // The held event moves into the state when the result slot is free or is
  // being emptied in this same cycle.
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_fire) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  rbwc_next u_next (
    .cfg_i      (cfg),
    .state_i    (state_q),
    .kind_i     (kind_q),
    .time_now_i (time_now_q),
    .state_o    (state_nxt)
  );

  // The state only moves when a result is produced, so it stays put while
  // the result beat it reports is waiting to be taken.
  assign state_d = advance ? state_nxt : state_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= rbwc_pkg::StateRst;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      state_q     <= state_d;
    end
  end

  // Event payload register; qualified by in_valid_q.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      kind_q     <= kind_i;
      time_now_q <= time_now_i;
    end
  end

  assign out_valid_o            = out_valid_q;
  assign band_is_hf_o           = state_q.band_hf;
  assign window_open_o          = state_q.hf_window;
  assign primary_rx_armed_o     = state_q.rx_armed;
  assign tx_busy_o              = state_q.radio_busy;
  assign latch_set_o            = state_q.tx_latch;
  assign modem_forced_hf_o      = state_q.forced_modem;
  assign tx_queued_o            = state_q.pending_tx;
  assign state_consistent_o     = state_q.hf_window == state_q.band_hf;
  assign switch_attempt_count_o = state_q.attempts;
  assign switch_bail_count_o    = state_q.bails;
  assign latch_clear_count_o    = state_q.force_clears;

endmodule

`default_nettype wire

// ===== tb/radio_band_window_monitor.sv =====
// ----------------------------------------------------------------------------
// radio_band_window_monitor
// Watches the band window controller's channels and predicts every result.
// ----------------------------------------------------------------------------
// Register writes and accepted event beats drive a private model of the
// controller state. Every result beat is compared field by field with the
// oldest predicted status.
// ----------------------------------------------------------------------------

module radio_band_window_monitor
  import rbwc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [2:0]  kind_i,
  input  logic [31:0] time_now_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic        band_is_hf_i,
  input  logic        window_open_i,
  input  logic        primary_rx_armed_i,
  input  logic        tx_busy_i,
  input  logic        latch_set_i,
  input  logic        modem_forced_hf_i,
  input  logic        tx_queued_i,
  input  logic        state_consistent_i,
  input  logic [15:0] switch_attempt_count_i,
  input  logic [15:0] switch_bail_count_i,
  input  logic [15:0] latch_clear_count_i,
  output int          mismatches_o,
  output int          outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic        band_is_hf;
    logic        window_open;
    logic        primary_rx_armed;
    logic        tx_busy;
    logic        latch_set;
    logic        modem_forced_hf;
    logic        tx_queued;
    logic        state_consistent;
    logic [15:0] switch_attempt_count;
    logic [15:0] switch_bail_count;
    logic [15:0] latch_clear_count;
  } status_t;

  state_t  radio_state;
  cfg_t    regs;
  status_t expected_status_q[$];
  int      failures = 0;

  assign mismatches_o = failures;

  function automatic logic [15:0] sat_bump(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic state_t launch_hf_tx(input state_t s, input logic [31:0] now);
    if (!s.radio_busy) begin
      s.forced_modem = 1'b1;
      s.radio_busy   = 1'b1;
      s.tx_latch     = 1'b1;
      s.latch_stamp  = now;
    end
    return s;
  endfunction

  function automatic state_t next_radio_state(input state_t s, input cfg_t c,
                                              input kind_e k, input logic [31:0] now);
    logic [31:0] age;
    logic        latch_holds;
    age = now - s.latch_stamp;
    case (k)
      EV_TICK: begin
        // In legacy mode a held latch blocks ticks forever; in fix mode only
        // until its age reaches the timeout.
        latch_holds = s.tx_latch &&
                      (!c.fix_mode || age < {16'd0, c.latch_timeout_ms});
        if (!latch_holds) begin
          if (s.tx_latch) begin
            s.tx_latch     = 1'b0;
            s.forced_modem = 1'b0;
            s.force_clears = sat_bump(s.force_clears);
          end
          if (!s.hf_window) begin
            // Opening only happens when idle, so the switch cannot bail.
            if (!s.radio_busy) begin
              s.attempts  = sat_bump(s.attempts);
              s.band_hf   = 1'b1;
              s.rx_armed  = 1'b0;
              s.hf_window = 1'b1;
              if (s.pending_tx) begin
                s.pending_tx = 1'b0;
                s = launch_hf_tx(s, now);
              end
            end
          end else begin
            if (c.fix_mode) s.forced_modem = 1'b0;
            s.attempts = sat_bump(s.attempts);
            if (s.radio_busy) begin
              s.bails = sat_bump(s.bails);
              // Legacy mode drops the window flag even though the band stays.
              if (!c.fix_mode) s.hf_window = 1'b0;
            end else begin
              s.band_hf   = 1'b0;
              s.rx_armed  = 1'b1;
              s.hf_window = 1'b0;
            end
          end
        end
      end
      EV_START_HF_TX: s = launch_hf_tx(s, now);
      EV_TX_COMPLETE: begin
        s.forced_modem = 1'b0;
        s.tx_latch     = 1'b0;
        s.radio_busy   = 1'b0;
      end
      EV_RECOVER_RX: begin
        if (c.fix_mode) begin
          s.forced_modem = 1'b0;
          s.band_hf      = 1'b0;
          s.rx_armed     = 1'b1;
        end else if (s.forced_modem) begin
          s.band_hf  = 1'b1;
          s.rx_armed = 1'b0;
        end else begin
          s.band_hf  = 1'b0;
          s.rx_armed = 1'b1;
        end
      end
      EV_PRI_TX_START: begin
        s.radio_busy = 1'b1;
        s.rx_armed   = 1'b0;
      end
      EV_PRI_TX_DONE: begin
        s.radio_busy = 1'b0;
        s.rx_armed   = 1'b1;
      end
      EV_HF_TX_LOST: s.radio_busy = 1'b0;
      default: s.pending_tx = 1'b1;
    endcase
    return s;
  endfunction

  function automatic status_t status_of(input state_t s);
    status_t r;
    r.band_is_hf           = s.band_hf;
    r.window_open          = s.hf_window;
    r.primary_rx_armed     = s.rx_armed;
    r.tx_busy              = s.radio_busy;
    r.latch_set            = s.tx_latch;
    r.modem_forced_hf      = s.forced_modem;
    r.tx_queued            = s.pending_tx;
    r.state_consistent     = (s.hf_window == s.band_hf);
    r.switch_attempt_count = s.attempts;
    r.switch_bail_count    = s.bails;
    r.latch_clear_count    = s.force_clears;
    return r;
  endfunction

  function automatic void compare_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      failures++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track
    status_t want;
    if (!rst_ni) begin
      radio_state = StateRst;
      regs.fix_mode         = FixModeRst;
      regs.latch_timeout_ms = LatchTimeoutRst;
      expected_status_q.delete();
      outstanding_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_status_q.size() == 0) begin
          $error("result beat arrived with no event waiting for it");
          failures++;
        end else begin
          want = expected_status_q.pop_front();
          compare_field("band_is_hf", want.band_is_hf, band_is_hf_i);
          compare_field("window_open", want.window_open, window_open_i);
          compare_field("primary_rx_armed", want.primary_rx_armed, primary_rx_armed_i);
          compare_field("tx_busy", want.tx_busy, tx_busy_i);
          compare_field("latch_set", want.latch_set, latch_set_i);
          compare_field("modem_forced_hf", want.modem_forced_hf, modem_forced_hf_i);
          compare_field("tx_queued", want.tx_queued, tx_queued_i);
          compare_field("state_consistent", want.state_consistent, state_consistent_i);
          compare_field("switch_attempt_count", want.switch_attempt_count,
                        switch_attempt_count_i);
          compare_field("switch_bail_count", want.switch_bail_count, switch_bail_count_i);
          compare_field("latch_clear_count", want.latch_clear_count, latch_clear_count_i);
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_FIX_MODE:      regs.fix_mode = cfg_data_i[0];
          CFG_LATCH_TIMEOUT: regs.latch_timeout_ms = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        radio_state = next_radio_state(radio_state, regs, kind_e'(kind_i), time_now_i);
        expected_status_q.push_back(status_of(radio_state));
      end
      outstanding_o <= expected_status_q.size();
    end
  end

endmodule

// ===== tb/radio_band_window_controller_tb.sv =====
// ----------------------------------------------------------------------------
// radio_band_window_controller_tb
// Stimulus and verdict for the radio band window controller.
// ----------------------------------------------------------------------------
// A short directed run walks the latch timeout boundary, legacy behavior,
// refused switches and recovery. Randomized phases then sweep the register
// settings and the idle patterns of both channels. Checking lives in the
// monitor.
// ----------------------------------------------------------------------------

module radio_band_window_controller_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rbwc_pkg::*;

  // Generous cycle bound for a full run, even when both channels idle heavily.
  localparam int CycleLimit = 20_000;
  localparam int PhaseCount = 8;
  localparam int PhaseBeats = 53;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  cfg_idx_e    cfg_index_i = CFG_FIX_MODE;
  logic [15:0] cfg_data_i  = '0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  kind_e       kind_i      = EV_TICK;
  logic [31:0] time_now_i  = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        band_is_hf_o;
  logic        window_open_o;
  logic        primary_rx_armed_o;
  logic        tx_busy_o;
  logic        latch_set_o;
  logic        modem_forced_hf_o;
  logic        tx_queued_o;
  logic        state_consistent_o;
  logic [15:0] switch_attempt_count_o;
  logic [15:0] switch_bail_count_o;
  logic [15:0] latch_clear_count_o;

  int mismatches;
  int outstanding;

  // Idle rates in percent per cycle, changed from phase to phase.
  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  int          cycles         = 0;
  // Running millisecond clock handed to the block with every event.
  logic [31:0] clock_ms       = '0;

  always #5 clk_i = ~clk_i;

  radio_band_window_controller u_dut (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .cfg_valid_i            (cfg_valid_i),
    .cfg_ready_o            (cfg_ready_o),
    .cfg_index_i            (cfg_index_i),
    .cfg_data_i             (cfg_data_i),
    .in_valid_i             (in_valid_i),
    .in_ready_o             (in_ready_o),
    .kind_i                 (kind_i),
    .time_now_i             (time_now_i),
    .out_valid_o            (out_valid_o),
    .out_ready_i            (out_ready_i),
    .band_is_hf_o           (band_is_hf_o),
    .window_open_o          (window_open_o),
    .primary_rx_armed_o     (primary_rx_armed_o),
    .tx_busy_o              (tx_busy_o),
    .latch_set_o            (latch_set_o),
    .modem_forced_hf_o      (modem_forced_hf_o),
    .tx_queued_o            (tx_queued_o),
    .state_consistent_o     (state_consistent_o),
    .switch_attempt_count_o (switch_attempt_count_o),
    .switch_bail_count_o    (switch_bail_count_o),
    .latch_clear_count_o    (latch_clear_count_o)
  );

  radio_band_window_monitor u_status_check (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .cfg_valid_i            (cfg_valid_i),
    .cfg_ready_i            (cfg_ready_o),
    .cfg_index_i            (cfg_index_i),
    .cfg_data_i             (cfg_data_i),
    .in_valid_i             (in_valid_i),
    .in_ready_i             (in_ready_o),
    .kind_i                 (kind_i),
    .time_now_i             (time_now_i),
    .out_valid_i            (out_valid_o),
    .out_ready_i            (out_ready_i),
    .band_is_hf_i           (band_is_hf_o),
    .window_open_i          (window_open_o),
    .primary_rx_armed_i     (primary_rx_armed_o),
    .tx_busy_i              (tx_busy_o),
    .latch_set_i            (latch_set_o),
    .modem_forced_hf_i      (modem_forced_hf_o),
    .tx_queued_i            (tx_queued_o),
    .state_consistent_i     (state_consistent_o),
    .switch_attempt_count_i (switch_attempt_count_o),
    .switch_bail_count_i    (switch_bail_count_o),
    .latch_clear_count_i    (latch_clear_count_o),
    .mismatches_o           (mismatches),
    .outstanding_o          (outstanding)
  );

  // The result side stalls independently of the event side. A single
  // assignment per edge keeps the ready level free of same-step glitches.
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Watchdog: a hung handshake or a missing result ends the run here.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Offers one event beat. Valid only drops while the sender idles, so back
  // to back beats keep it high without a same-step low-then-high.
  task automatic send_event(input kind_e k, input logic [31:0] t);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i     <= k;
    time_now_i <= t;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Stops sending and waits until the monitor has seen every result. The
  // monitor's count is registered, so this can only err on the late side.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
  endtask

  // Writes both registers back to back once the controller is idle. Every
  // event yields a result, so no extra settling time is needed.
  task automatic program_regs(input logic fix, input logic [15:0] timeout_ms);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CFG_FIX_MODE;
    cfg_data_i  <= {15'd0, fix};
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_index_i <= CFG_LATCH_TIMEOUT;
    cfg_data_i  <= timeout_ms;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  // Moves the clock mostly in steps that straddle the latch timeout, with
  // occasional jumps to arbitrary values and to just below the wrap point.
  function automatic logic [31:0] advance_clock(input logic [15:0] timeout_ms);
    int r;
    r = $urandom_range(0, 99);
    if (r < 6) begin
      clock_ms = $urandom();
    end else if (r < 10) begin
      clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 63);
    end else if (r < 22) begin
      clock_ms = clock_ms;
    end else if (r < 30) begin
      clock_ms = clock_ms + timeout_ms;
    end else if (r < 36) begin
      clock_ms = clock_ms + timeout_ms - 1;
    end else begin
      clock_ms = clock_ms + $urandom_range(1, timeout_ms / 2 + 1);
    end
    return clock_ms;
  endfunction

  // Ticks dominate so that windows open and close often; queue requests are
  // common enough that many openings carry a pending transmit.
  function automatic kind_e pick_event();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return EV_TICK;
    if (r < 50) return EV_QUEUE_HF_TX;
    return kind_e'(3'($urandom_range(1, 6)));
  endfunction

  initial begin : stimulus
    logic        fix_tab [PhaseCount];
    logic [15:0] timeout_tab [PhaseCount];

    fix_tab     = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
    timeout_tab = '{16'd1000, 16'd65535, 16'd0, 16'd0, 16'd65535,
                    16'($urandom_range(2, 300)), 16'($urandom_range(2, 300)), 16'd1};

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part under the reset register values: fix mode, 1000 ms.
    send_event(EV_TICK, 32'd0);             // open the window
    send_event(EV_TICK, 32'd5);             // and close it again
    send_event(EV_QUEUE_HF_TX, 32'd10);
    send_event(EV_TICK, 32'd20);            // opening launches the queued transmit
    send_event(EV_START_HF_TX, 32'd30);     // start while busy is ignored
    send_event(EV_TICK, 32'd1019);          // latch age one short of the timeout
    send_event(EV_TICK, 32'd1020);          // exact timeout: clear, then refused close
    send_event(EV_RECOVER_RX, 32'd1021);    // window open on the primary band
    send_event(EV_HF_TX_LOST, 32'd1022);
    send_event(EV_TICK, 32'd1023);
    send_event(EV_PRI_TX_START, 32'd1024);
    send_event(EV_TICK, 32'd1025);          // busy with the window closed
    send_event(EV_PRI_TX_DONE, 32'd1026);
    send_event(EV_TX_COMPLETE, 32'd1027);

    // Legacy mode with the largest timeout and a stamp at the top of the range.
    program_regs(1'b0, 16'hFFFF);
    send_event(EV_TICK, 32'hFFFF_FFF0);
    send_event(EV_START_HF_TX, 32'hFFFF_FFFF);
    send_event(EV_TICK, 32'd0);             // a held latch blocks every tick
    send_event(EV_RECOVER_RX, 32'd1);       // forced modem keeps the HF band
    send_event(EV_TX_COMPLETE, 32'd2);
    send_event(EV_PRI_TX_START, 32'd3);
    send_event(EV_TICK, 32'd4);             // refused close still drops the window
    send_event(EV_RECOVER_RX, 32'd5);
    send_event(EV_PRI_TX_DONE, 32'd6);

    // A zero timeout clears the latch at the very first tick.
    program_regs(1'b1, 16'd0);
    send_event(EV_START_HF_TX, 32'd100);
    send_event(EV_TICK, 32'd100);
    send_event(EV_TX_COMPLETE, 32'd101);

    // Random phases: each one rewrites both registers and takes one of the
    // four idle patterns, so gaps land on every part of the handshake.
    for (int p = 0; p < PhaseCount; p++) begin
      program_regs(fix_tab[p], timeout_tab[p]);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
        default: begin send_idle_pct = 9; recv_stall_pct = 9; end
      endcase
      for (int i = 0; i < PhaseBeats; i++) begin
        send_event(pick_event(), advance_clock(timeout_tab[p]));
        // Once, hold off in mid-phase until the pipeline has run dry.
        if (p == 5 && i == PhaseBeats / 2) wait_drained();
      end
    end

    // Let any stray result beat show up before the verdict.
    wait_drained();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && outstanding == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== radio_band_window_controller.f =====
sv/rbwc_pkg.sv
sv/rbwc_cfg.sv
sv/rbwc_next.sv
sv/radio_band_window_controller.sv
tb/radio_band_window_monitor.sv
tb/radio_band_window_controller_tb.sv
